### hw/rtl/sks_pkg.sv
// Shared types and constants for the string key selection sort block.
// Used by the controller, the datapath and the top level; no dependencies.
package sks_pkg;

  localparam int unsigned MAX_RECORDS_DEF    = 64;
  localparam int unsigned MAX_NAME_BYTES_DEF = 256;
  localparam int unsigned KEY_W              = 8;
  localparam int unsigned TAG_W              = 16;
  localparam int unsigned RCNT_W             = 7;
  localparam int unsigned CCNT_W             = 11;
  localparam int unsigned MCNT_W             = 8;
  localparam logic [MCNT_W-1:0] MOVES_PER_SWAP = MCNT_W'(3);
  localparam int unsigned S_TDATA_W          = 24;
  localparam int unsigned M_TDATA_W          = 48;

  typedef enum logic [4:0] {
    CMD_LOAD,
    CMD_START,
    CMD_INIT,
    CMD_ORD_I,
    CMD_LEN_I,
    CMD_LEN_I2,
    CMD_ORD_J,
    CMD_LEN_J,
    CMD_CMP_SETUP,
    CMD_BYTE_RD,
    CMD_BYTE_CMP,
    CMD_NEXT_J,
    CMD_SWAP_A,
    CMD_SWAP_B,
    CMD_NEXT_I,
    CMD_EMIT_ORD,
    CMD_EMIT_TAG,
    CMD_EMIT_OUT,
    CMD_EMPTY
  } cmd_e;

  typedef struct packed {
    logic term_last;
    logic cnt_zero;
    logic n_one;
    logic init_end;
    logic j_end;
    logic i_end;
    logic bytes_done;
    logic byte_ne;
    logic swap_needed;
    logic out_free;
    logic emit_last;
  } status_t;

endpackage

### hw/rtl/sks_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module sks_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/sks_ctrl.sv
// Sequencer for load, sort and emission of the selection sort block.
// Depends on sks_pkg; drives commands to sks_datapath.
module sks_ctrl
  import sks_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output cmd_e    cmd_o
);

  typedef enum logic [18:0] {
    ST_LOAD      = 19'b0000000000000000001,
    ST_START     = 19'b0000000000000000010,
    ST_INIT      = 19'b0000000000000000100,
    ST_ORD_I     = 19'b0000000000000001000,
    ST_LEN_I     = 19'b0000000000000010000,
    ST_LEN_I2    = 19'b0000000000000100000,
    ST_ORD_J     = 19'b0000000000001000000,
    ST_LEN_J     = 19'b0000000000010000000,
    ST_CMP_SETUP = 19'b0000000000100000000,
    ST_BYTE_RD   = 19'b0000000001000000000,
    ST_BYTE_CMP  = 19'b0000000010000000000,
    ST_NEXT_J    = 19'b0000000100000000000,
    ST_SWAP_A    = 19'b0000001000000000000,
    ST_SWAP_B    = 19'b0000010000000000000,
    ST_NEXT_I    = 19'b0000100000000000000,
    ST_EMIT_ORD  = 19'b0001000000000000000,
    ST_EMIT_TAG  = 19'b0010000000000000000,
    ST_EMIT_OUT  = 19'b0100000000000000000,
    ST_EMPTY     = 19'b1000000000000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_LOAD;
    unique case (state_q)
      ST_LOAD: begin
        cmd_o = CMD_LOAD;
        if (status_i.term_last) state_d = ST_START;
      end
      ST_START: begin
        cmd_o   = CMD_START;
        state_d = status_i.cnt_zero ? ST_EMPTY : ST_INIT;
      end
      ST_INIT: begin
        cmd_o = CMD_INIT;
        if (status_i.init_end) state_d = status_i.n_one ? ST_EMIT_ORD : ST_ORD_I;
      end
      ST_ORD_I: begin
        cmd_o   = CMD_ORD_I;
        state_d = ST_LEN_I;
      end
      ST_LEN_I: begin
        cmd_o   = CMD_LEN_I;
        state_d = ST_LEN_I2;
      end
      ST_LEN_I2: begin
        cmd_o   = CMD_LEN_I2;
        state_d = ST_ORD_J;
      end
      ST_ORD_J: begin
        cmd_o   = CMD_ORD_J;
        state_d = ST_LEN_J;
      end
      ST_LEN_J: begin
        cmd_o   = CMD_LEN_J;
        state_d = ST_CMP_SETUP;
      end
      ST_CMP_SETUP: begin
        cmd_o   = CMD_CMP_SETUP;
        state_d = ST_BYTE_RD;
      end
      ST_BYTE_RD: begin
        cmd_o   = CMD_BYTE_RD;
        state_d = status_i.bytes_done ? ST_NEXT_J : ST_BYTE_CMP;
      end
      ST_BYTE_CMP: begin
        cmd_o   = CMD_BYTE_CMP;
        state_d = status_i.byte_ne ? ST_NEXT_J : ST_BYTE_RD;
      end
      ST_NEXT_J: begin
        cmd_o   = CMD_NEXT_J;
        state_d = status_i.j_end ? ST_SWAP_A : ST_ORD_J;
      end
      ST_SWAP_A: begin
        cmd_o   = CMD_SWAP_A;
        state_d = status_i.swap_needed ? ST_SWAP_B : ST_NEXT_I;
      end
      ST_SWAP_B: begin
        cmd_o   = CMD_SWAP_B;
        state_d = ST_NEXT_I;
      end
      ST_NEXT_I: begin
        cmd_o   = CMD_NEXT_I;
        state_d = status_i.i_end ? ST_EMIT_ORD : ST_ORD_I;
      end
      ST_EMIT_ORD: begin
        cmd_o   = CMD_EMIT_ORD;
        state_d = ST_EMIT_TAG;
      end
      ST_EMIT_TAG: begin
        cmd_o   = CMD_EMIT_TAG;
        state_d = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        cmd_o = CMD_EMIT_OUT;
        if (status_i.out_free) state_d = status_i.emit_last ? ST_LOAD : ST_EMIT_ORD;
      end
      ST_EMPTY: begin
        cmd_o = CMD_EMPTY;
        if (status_i.out_free) state_d = ST_LOAD;
      end
      default: begin
        cmd_o   = CMD_LOAD;
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hw/rtl/sks_datapath.sv
// Storage, counters, compare logic and output register of the sort block.
// Depends on sks_pkg and sks_ram; commanded by sks_ctrl.
module sks_datapath
  import sks_pkg::*;
#(
  parameter int unsigned MAX_RECORDS    = MAX_RECORDS_DEF,
  parameter int unsigned MAX_NAME_BYTES = MAX_NAME_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_e                 cmd_i,
  output status_t              status_o,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  output logic                 m_axis_tuser,
  output logic                 m_axis_tlast
);

  localparam int unsigned RW = $clog2(MAX_RECORDS);
  localparam int unsigned CW = $clog2(MAX_RECORDS + 1);
  localparam int unsigned BW = $clog2(MAX_NAME_BYTES);
  localparam int unsigned LW = $clog2(MAX_NAME_BYTES + 1);
  localparam int unsigned NDEPTH = MAX_RECORDS * (2 ** BW);
  localparam logic [CW-1:0] MAX_REC_C = CW'(MAX_RECORDS);
  localparam logic [LW-1:0] MAX_NB_C  = LW'(MAX_NAME_BYTES);

  logic [KEY_W-1:0] key;
  logic [TAG_W-1:0] tag_in;
  logic             fire;
  logic [CW-1:0]    loaded_q, loaded_d;
  logic [LW-1:0]    pos_q, pos_d;
  logic             ovf_q, ovf_d;
  logic [CW-1:0]    i_q, i_d, j_q, j_d, best_q, best_d;
  logic [RW-1:0]    irec_q, irec_d, brec_q, brec_d, jrec_q, jrec_d;
  logic [LW-1:0]    blen_q, blen_d, jlen_q, jlen_d, k_q, k_d, minlen;
  logic             less_q, less_d;
  logic [CCNT_W-1:0] comps_q, comps_d;
  logic [MCNT_W-1:0] moves_q, moves_d;

  logic                 out_valid_q, out_valid_d, out_free, out_load;
  logic [M_TDATA_W-1:0] out_data_q, out_data_d;
  logic                 out_user_q, out_user_d, out_last_q, out_last_d;

  logic              name_we, tag_we, len_we, ord_we;
  logic [RW+BW-1:0]  name_waddr, name_raddr_a, name_raddr_b;
  logic [KEY_W-1:0]  name_rdata_a, name_rdata_b;
  logic [RW-1:0]     rec_waddr, len_raddr, tag_raddr, ord_waddr, ord_raddr;
  logic [RW-1:0]     ord_wdata, ord_rdata;
  logic [LW-1:0]     len_rdata;
  logic [TAG_W-1:0]  tag_rdata;
  logic              emit_last;

  assign key    = s_axis_tdata[KEY_W-1:0];
  assign tag_in = s_axis_tdata[KEY_W+TAG_W-1:KEY_W];
  assign s_axis_tready = (cmd_i == CMD_LOAD);
  assign fire   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign minlen = (jlen_q < blen_q) ? jlen_q : blen_q;
  assign emit_last = ({1'b0, i_q} + (CW+1)'(1)) == {1'b0, loaded_q};

  assign status_o.term_last   = fire && (key == '0) && s_axis_tlast;
  assign status_o.cnt_zero    = (loaded_q == '0);
  assign status_o.n_one       = (loaded_q == CW'(1));
  assign status_o.init_end    = emit_last;
  assign status_o.j_end       = ({1'b0, j_q} + (CW+1)'(1)) >= {1'b0, loaded_q};
  assign status_o.i_end       = ({1'b0, i_q} + (CW+1)'(2)) >= {1'b0, loaded_q};
  assign status_o.bytes_done  = (k_q >= minlen);
  assign status_o.byte_ne     = (name_rdata_a != name_rdata_b);
  assign status_o.swap_needed = (best_q != i_q);
  assign status_o.out_free    = out_free;
  assign status_o.emit_last   = emit_last;

  assign name_waddr   = {loaded_q[RW-1:0], pos_q[BW-1:0]};
  assign name_raddr_a = {jrec_q, k_q[BW-1:0]};
  assign name_raddr_b = {brec_q, k_q[BW-1:0]};
  assign rec_waddr    = loaded_q[RW-1:0];
  assign len_raddr    = ord_rdata;
  assign tag_raddr    = ord_rdata;
  assign name_we = fire && (key != '0) && (loaded_q < MAX_REC_C) && (pos_q < MAX_NB_C);
  assign tag_we  = fire && (key == '0) && (loaded_q < MAX_REC_C);
  assign len_we  = tag_we;

  always_comb begin
    ord_we    = 1'b0;
    ord_waddr = i_q[RW-1:0];
    ord_wdata = i_q[RW-1:0];
    ord_raddr = i_q[RW-1:0];
    loaded_d = loaded_q;
    pos_d    = pos_q;
    ovf_d    = ovf_q;
    i_d      = i_q;
    j_d      = j_q;
    best_d   = best_q;
    irec_d   = irec_q;
    brec_d   = brec_q;
    jrec_d   = jrec_q;
    blen_d   = blen_q;
    jlen_d   = jlen_q;
    k_d      = k_q;
    less_d   = less_q;
    comps_d  = comps_q;
    moves_d  = moves_q;
    out_load   = 1'b0;
    out_data_d = out_data_q;
    out_user_d = out_user_q;
    out_last_d = out_last_q;
    unique case (cmd_i)
      CMD_LOAD: begin
        if (fire) begin
          if (key != '0) begin
            if (loaded_q < MAX_REC_C) begin
              if (pos_q < MAX_NB_C) pos_d = pos_q + LW'(1);
              else ovf_d = 1'b1;
            end
          end else begin
            if (loaded_q < MAX_REC_C) loaded_d = loaded_q + CW'(1);
            else ovf_d = 1'b1;
            pos_d = '0;
          end
        end
      end
      CMD_START: begin
        i_d     = '0;
        comps_d = '0;
        moves_d = '0;
      end
      CMD_INIT: begin
        ord_we = 1'b1;
        i_d    = emit_last ? '0 : i_q + CW'(1);
      end
      CMD_ORD_I: ord_raddr = i_q[RW-1:0];
      CMD_LEN_I: begin
        irec_d = ord_rdata;
        brec_d = ord_rdata;
        best_d = i_q;
        j_d    = i_q + CW'(1);
      end
      CMD_LEN_I2: blen_d = len_rdata;
      CMD_ORD_J: ord_raddr = j_q[RW-1:0];
      CMD_LEN_J: jrec_d = ord_rdata;
      CMD_CMP_SETUP: begin
        jlen_d  = len_rdata;
        k_d     = '0;
        comps_d = comps_q + CCNT_W'(1);
      end
      CMD_BYTE_RD: begin
        if (k_q >= minlen) less_d = (jlen_q < blen_q);
      end
      CMD_BYTE_CMP: begin
        if (name_rdata_a != name_rdata_b) less_d = (name_rdata_a < name_rdata_b);
        else k_d = k_q + LW'(1);
      end
      CMD_NEXT_J: begin
        if (less_q) begin
          best_d = j_q;
          brec_d = jrec_q;
          blen_d = jlen_q;
        end
        j_d = j_q + CW'(1);
      end
      CMD_SWAP_A: begin
        if (best_q != i_q) begin
          ord_we    = 1'b1;
          ord_wdata = brec_q;
          moves_d   = moves_q + MOVES_PER_SWAP;
        end
      end
      CMD_SWAP_B: begin
        ord_we    = 1'b1;
        ord_waddr = best_q[RW-1:0];
        ord_wdata = irec_q;
      end
      CMD_NEXT_I: i_d = status_o.i_end ? '0 : i_q + CW'(1);
      CMD_EMIT_ORD: ord_raddr = i_q[RW-1:0];
      CMD_EMIT_TAG: ord_raddr = i_q[RW-1:0];
      CMD_EMIT_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_data_d = M_TDATA_W'({moves_q, comps_q, RCNT_W'(loaded_q), tag_rdata});
          out_user_d = ovf_q;
          out_last_d = emit_last;
          i_d        = i_q + CW'(1);
          if (emit_last) begin
            loaded_d = '0;
            pos_d    = '0;
            ovf_d    = 1'b0;
          end
        end
      end
      CMD_EMPTY: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_data_d = '0;
          out_user_d = ovf_q;
          out_last_d = 1'b1;
          loaded_d   = '0;
          pos_d      = '0;
          ovf_d      = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) out_valid_d = 1'b0;
    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q    <= '0;
      pos_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      best_q      <= '0;
      k_q         <= '0;
      less_q      <= 1'b0;
      comps_q     <= '0;
      moves_q     <= '0;
    end else begin
      loaded_q    <= loaded_d;
      pos_q       <= pos_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      i_q         <= i_d;
      j_q         <= j_d;
      best_q      <= best_d;
      k_q         <= k_d;
      less_q      <= less_d;
      comps_q     <= comps_d;
      moves_q     <= moves_d;
    end
  end

  always_ff @(posedge clk_i) begin
    irec_q     <= irec_d;
    brec_q     <= brec_d;
    jrec_q     <= jrec_d;
    blen_q     <= blen_d;
    jlen_q     <= jlen_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

  sks_ram #(.WIDTH(KEY_W), .DEPTH(NDEPTH)) u_name_a (
    .clk_i, .we_i(name_we), .waddr_i(name_waddr), .wdata_i(key),
    .raddr_i(name_raddr_a), .rdata_o(name_rdata_a)
  );

  sks_ram #(.WIDTH(KEY_W), .DEPTH(NDEPTH)) u_name_b (
    .clk_i, .we_i(name_we), .waddr_i(name_waddr), .wdata_i(key),
    .raddr_i(name_raddr_b), .rdata_o(name_rdata_b)
  );

  sks_ram #(.WIDTH(LW), .DEPTH(MAX_RECORDS)) u_len (
    .clk_i, .we_i(len_we), .waddr_i(rec_waddr), .wdata_i(pos_q),
    .raddr_i(len_raddr), .rdata_o(len_rdata)
  );

  sks_ram #(.WIDTH(TAG_W), .DEPTH(MAX_RECORDS)) u_tag (
    .clk_i, .we_i(tag_we), .waddr_i(rec_waddr), .wdata_i(tag_in),
    .raddr_i(tag_raddr), .rdata_o(tag_rdata)
  );

  sks_ram #(.WIDTH(RW), .DEPTH(MAX_RECORDS)) u_ord (
    .clk_i, .we_i(ord_we), .waddr_i(ord_waddr), .wdata_i(ord_wdata),
    .raddr_i(ord_raddr), .rdata_o(ord_rdata)
  );

  a_loaded_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q <= MAX_REC_C) else $error("record count above capacity");
  a_pos_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= MAX_NB_C) else $error("byte position above capacity");
  a_byte_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_BYTE_CMP) |-> (k_q < minlen)) else $error("byte compare past name end");
  a_swap_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_SWAP_B) |-> (best_q > i_q)) else $error("swap with earlier slot");
  a_load_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q) else $error("result register not filled");

endmodule

### hw/rtl/string_key_selection_sort.sv
// Top level of the string key selection sort block.
// Depends on sks_pkg, sks_ctrl and sks_datapath.
//
// Input stream: one transaction per name byte. tdata[7:0] is the byte; a zero
// byte ends a record and tdata[23:8] carries its tag. tlast on a terminator
// starts the sort. Up to MAX_RECORDS records of up to MAX_NAME_BYTES bytes.
// Loading takes one transaction per cycle. After the final terminator the
// input stalls while one sequencer walks the stored keys: a start step, an
// order table fill over all records, per outer pass order and length reads,
// per compare a setup step and alternating byte read and compare steps, a
// swap when needed, then per result an order read, a tag read and the load,
// paced by the registered reads of the name, length, tag and order memories.
// Output stream: one transaction per record in ascending strcmp order;
// tdata holds from bit 0 up sorted_tag[15:0], record_count[22:16],
// compare_count[33:23], move_count[41:34]; tuser = dropped; tlast marks the
// final result. An empty load yields one result with zero tdata and tlast
// set. The result register holds while the receiver stalls and loading
// resumes behind the last result.
// Reset clears all control state; stored names start undefined.
module string_key_selection_sort
  import sks_pkg::*;
#(
  parameter int unsigned MAX_RECORDS    = MAX_RECORDS_DEF,
  parameter int unsigned MAX_NAME_BYTES = MAX_NAME_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // key_byte, record_tag
  input  logic                 s_axis_tlast,  // last_record
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // sorted_tag, record_count, compare, move
  output logic                 m_axis_tuser,  // dropped
  output logic                 m_axis_tlast   // last_of_run
);

  cmd_e    cmd;
  status_t status;

  sks_ctrl u_ctrl (
    .clk_i, .rst_ni, .status_i(status), .cmd_o(cmd)
  );

  sks_datapath #(
    .MAX_RECORDS(MAX_RECORDS), .MAX_NAME_BYTES(MAX_NAME_BYTES)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status),
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

endmodule
